// File: design/pos_pi_pkg.sv
`timescale 1ns / 1ps

package pos_pi_pkg;

   localparam int POS_W   = 24;
   localparam int VEL_W   = 16;
   localparam int ERR_W   = 25;
   localparam int DUTY_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int INTEG_W = 24;
   localparam int CSR_IDX_W = 3;

   // integral limit of +/-32000.0 in Q.8
   localparam logic signed [INTEG_W-1:0] INTEGRAL_LIMIT = 24'sd8192000;

   localparam logic [GAIN_W-1:0] MAX_PWM_RESET = 16'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN      = 3'd0,
      CSR_KI_GAIN      = 3'd1,
      CSR_FF_GAIN      = 3'd2,
      CSR_START_OFFSET = 3'd3,
      CSR_MAX_PWM      = 3'd4
   } csr_index_type;

endpackage

// File: design/pos_pi_if.sv
`timescale 1ns / 1ps

interface pos_pi_req_if
   import pos_pi_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] measured_pos;
   logic signed [POS_W-1:0] target_pos;
   logic signed [VEL_W-1:0] target_velocity;
   logic                    clear_state;

   modport source (
      output valid, measured_pos, target_pos, target_velocity, clear_state,
      input  ready
   );
   modport sink (
      input  valid, measured_pos, target_pos, target_velocity, clear_state,
      output ready
   );
endinterface

interface pos_pi_rsp_if
   import pos_pi_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty;
   logic                    windup_held;
   logic signed [ERR_W-1:0] position_error;

   modport source (
      output valid, duty, windup_held, position_error,
      input  ready
   );
   modport sink (
      input  valid, duty, windup_held, position_error,
      output ready
   );
endinterface

// File: design/position_pi_feedforward_pwm_top.sv
`timescale 1ns / 1ps
//  channel   direction  transfer when          payload
//  req_if    in         valid && ready         measured_pos, target_pos, target_velocity,
//                                              clear_state
//  rsp_if    out        valid && ready         duty, windup_held, position_error
//  csr_*     in         csr_wr_en              csr_index, csr_wr_data (16 bits)
//
//  One item per cycle unless rsp_if stalls; input register, then result register.
//  The three gain multiplies, integral update and duty clamp sit between those two.
//  The integral and last duty update when an item moves into the result register.
//  A stalled result holds both stages; the input stage still takes an item if empty.
//  Synchronous active-high reset empties both stages and restores the registers.

module position_pi_feedforward_pwm_top
   import pos_pi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pos_pi_req_if.sink            req_if,
   pos_pi_rsp_if.source          rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]     csr_wr_data
);

   // configuration
   logic [GAIN_W-1:0] kp_gain_ff, ki_gain_ff, ff_gain_ff, start_offset_ff, max_pwm_ff;

   // input stage
   logic                    s1_valid_ff;
   logic signed [POS_W-1:0] meas_ff;
   logic signed [POS_W-1:0] targ_ff;
   logic signed [VEL_W-1:0] vel_ff;
   logic                    clear_ff;

   // controller state
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic [DUTY_W-1:0]         last_duty_ff;

   // result stage
   logic                    rsp_valid_ff;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic                    held_ff, held_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic advance;
   logic req_fire;

   assign advance  = !rsp_valid_ff || rsp_if.ready;
   assign req_fire = req_if.valid && req_if.ready;

   assign req_if.ready = !s1_valid_ff || advance;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.duty           = duty_ff;
   assign rsp_if.windup_held    = held_ff;
   assign rsp_if.position_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff      <= '0;
         ki_gain_ff      <= '0;
         ff_gain_ff      <= '0;
         start_offset_ff <= '0;
         max_pwm_ff      <= MAX_PWM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_GAIN:      kp_gain_ff      <= csr_wr_data;
            CSR_KI_GAIN:      ki_gain_ff      <= csr_wr_data;
            CSR_FF_GAIN:      ff_gain_ff      <= csr_wr_data;
            CSR_START_OFFSET: start_offset_ff <= csr_wr_data;
            CSR_MAX_PWM:      max_pwm_ff      <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      logic signed [ERR_W-1:0]   lag;
      logic signed [41:0]        p_prod, p_adj;
      logic signed [25:0]        p_q;
      logic signed [15:0]        p_int;
      logic signed [41:0]        i_prod;
      logic signed [34:0]        cand;
      logic signed [33:0]        f_prod, f_adj;
      logic signed [17:0]        f_int;
      logic signed [INTEG_W-1:0] i_adj;
      logic signed [15:0]        i_int;
      logic signed [19:0]        sum;
      logic                      out_of_range;

      err_in = ERR_W'($signed(meas_ff)) - ERR_W'($signed(targ_ff));
      lag    = ERR_W'($signed(targ_ff)) - ERR_W'($signed(meas_ff));

      p_prod = 42'(lag) * 42'($signed({1'b0, kp_gain_ff}));
      p_adj  = p_prod + ((p_prod < 0) ? 42'sd65535 : 42'sd0);
      p_q    = p_adj[41:16];
      if (p_q > 26'sd32767)
         p_int = 16'sd32767;
      else if (p_q < -26'sd32768)
         p_int = -16'sd32768;
      else
         p_int = p_q[15:0];

      // arithmetic shift gives the floor to Q.8
      i_prod = 42'(lag) * 42'($signed({1'b0, ki_gain_ff}));
      cand   = 35'($signed(i_prod[41:8])) + 35'(integral_ff);

      f_prod = 34'(vel_ff) * 34'($signed({1'b0, ff_gain_ff}));
      f_adj  = f_prod + ((f_prod < 0) ? 34'sd65535 : 34'sd0);
      f_int  = f_adj[33:16];

      out_of_range = (cand > 35'(INTEGRAL_LIMIT)) || (cand < -35'(INTEGRAL_LIMIT));
      held_in      = out_of_range || (last_duty_ff >= max_pwm_ff);
      integral_in  = held_in ? integral_ff : cand[INTEG_W-1:0];

      i_adj = integral_in + ((integral_in < 0) ? 24'sd255 : 24'sd0);
      i_int = i_adj[23:8];

      sum = 20'(f_int) + 20'(p_int) + 20'(i_int) + 20'($signed({1'b0, start_offset_ff}));
      if (sum > $signed({4'b0, max_pwm_ff}))
         duty_in = max_pwm_ff;
      else if (sum < 0)
         duty_in = '0;
      else
         duty_in = sum[DUTY_W-1:0];

      if (clear_ff) begin
         integral_in = '0;
         duty_in     = '0;
         held_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         last_duty_ff <= '0;
      end else begin
         if (req_if.ready)
            s1_valid_ff <= req_if.valid;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               integral_ff  <= integral_in;
               last_duty_ff <= duty_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         meas_ff  <= req_if.measured_pos;
         targ_ff  <= req_if.target_pos;
         vel_ff   <= req_if.target_velocity;
         clear_ff <= req_if.clear_state;
      end
      if (advance && s1_valid_ff) begin
         duty_ff <= duty_in;
         held_ff <= held_in;
         err_ff  <= err_in;
      end
   end

`ifndef ASSERT_OFF
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (integral_ff <= INTEGRAL_LIMIT) && (integral_ff >= -INTEGRAL_LIMIT))
      else $error("integral left its limits");

   a_last_duty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_duty_ff == duty_ff))
      else $error("last duty differs from pending result");

   a_held_freezes: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && held_in) |=> $stable(integral_ff))
      else $error("integral moved while held");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && clear_ff) |=>
         (integral_ff == '0) && (last_duty_ff == '0) && (duty_ff == '0))
      else $error("clear did not zero state");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_if.ready))
      else $error("input stalled without back-pressure");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb
   import pos_pi_pkg::*;
();

   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int RANDOM_PHASES    = 7;
   localparam int PHASE_ITEMS      = 100;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam logic [GAIN_W-1:0]       GAIN_MAX = '1;

   typedef struct {
      logic [DUTY_W-1:0]       duty;
      logic                    windup_held;
      logic signed [ERR_W-1:0] position_error;
   } duty_result_type;

   // Predicts the duty stream of the controller and checks results in order.
   class duty_scoreboard;
      int              kp, ki, ff, offset, max_duty;
      longint          integ_q8;
      int              prev_duty;
      duty_result_type duty_q[$];
      int              errors;

      function new();
         kp        = 0;
         ki        = 0;
         ff        = 0;
         offset    = 0;
         max_duty  = MAX_PWM_RESET;
         integ_q8  = 0;
         prev_duty = 0;
         errors    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
         case (idx)
            CSR_KP_GAIN:      kp = value;
            CSR_KI_GAIN:      ki = value;
            CSR_FF_GAIN:      ff = value;
            CSR_START_OFFSET: offset = value;
            CSR_MAX_PWM:      max_duty = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [POS_W-1:0] measured,
                                 logic signed [POS_W-1:0] target,
                                 logic signed [VEL_W-1:0] velocity,
                                 logic clear);
         duty_result_type r;
         longint m, t, v, lag, err, p, incr, cand, ffv, sum;
         m   = measured;
         t   = target;
         v   = velocity;
         lag = t - m;
         err = m - t;
         r.position_error = err[ERR_W-1:0];
         r.windup_held    = 1'b0;
         r.duty           = '0;
         if (clear) begin
            integ_q8  = 0;
            prev_duty = 0;
         end else begin
            // integer parts truncate toward zero, the integral step rounds down
            p = (lag * kp) / 65536;
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            incr = (lag * ki) >>> 8;
            cand = integ_q8 + incr;
            if (cand > longint'(INTEGRAL_LIMIT) || cand < -longint'(INTEGRAL_LIMIT)
                || prev_duty >= max_duty) begin
               r.windup_held = 1'b1;
            end else begin
               integ_q8 = cand;
            end
            ffv = (v * ff) / 65536;
            sum = ffv + p + integ_q8 / 256 + offset;
            if (sum > max_duty) sum = max_duty;
            if (sum < 0) sum = 0;
            r.duty    = sum[DUTY_W-1:0];
            prev_duty = int'(sum);
         end
         duty_q.push_back(r);
      endfunction

      function void check_result(logic [DUTY_W-1:0] duty, logic held,
                                 logic signed [ERR_W-1:0] position_error);
         duty_result_type e;
         if (duty_q.size() == 0) begin
            $display("%0t: unexpected result, duty %0d held %0b error %0d",
                     $time, duty, held, position_error);
            errors++;
         end else begin
            e = duty_q.pop_front();
            if (duty !== e.duty) begin
               $display("%0t: duty mismatch, expected %0d, got %0d", $time, e.duty, duty);
               errors++;
            end
            if (held !== e.windup_held) begin
               $display("%0t: windup_held mismatch, expected %0b, got %0b",
                        $time, e.windup_held, held);
               errors++;
            end
            if (position_error !== e.position_error) begin
               $display("%0t: position_error mismatch, expected %0d, got %0d",
                        $time, e.position_error, position_error);
               errors++;
            end
         end
      endfunction

      function int pending();
         return duty_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wr_data;

   pos_pi_req_if req_if();
   pos_pi_rsp_if rsp_if();

   duty_scoreboard sb = new();
   int  burst_left = 0;
   bit  long_hold_request = 1'b0;

   position_pi_feedforward_pwm_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result checked first so a stray result never pairs with a same-edge request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.duty, rsp_if.windup_held, rsp_if.position_error);
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.measured_pos, req_if.target_pos,
                            req_if.target_velocity, req_if.clear_state);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb failed");
      $finish;
   end

   // receiver: segments of always-ready, loose and tight stall patterns
   initial begin
      int seg_left;
      int mode;
      seg_left = 0;
      mode     = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 50);
               mode     = $urandom_range(0, 2);
            end
            seg_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      sb.set_register(idx, data);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [GAIN_W-1:0] kp, ki, ff, offset, max_duty);
      write_csr(CSR_KP_GAIN, kp);
      write_csr(CSR_KI_GAIN, ki);
      write_csr(CSR_FF_GAIN, ff);
      write_csr(CSR_START_OFFSET, offset);
      write_csr(CSR_MAX_PWM, max_duty);
      // unused index, must leave every register alone
      write_csr(CSR_IDX_W'(CSR_MAX_PWM + 1 + $urandom_range(0, 2)), GAIN_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic offer(input logic signed [POS_W-1:0] measured, target,
                        input logic signed [VEL_W-1:0] velocity, input logic clear);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid           <= 1'b1;
      req_if.measured_pos    <= measured;
      req_if.target_pos      <= target;
      req_if.target_velocity <= velocity;
      req_if.clear_state     <= clear;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic offer_random();
      logic signed [POS_W-1:0] measured, target;
      logic signed [VEL_W-1:0] velocity;
      int sel;
      measured = POS_W'($urandom);
      sel = $urandom_range(0, 9);
      if (sel < 7)
         target = measured + POS_W'($signed($urandom_range(0, 4096)) - 2048);
      else if (sel < 9)
         target = measured + POS_W'($signed($urandom_range(0, 131072)) - 65536);
      else
         target = POS_W'($urandom);
      if ($urandom_range(0, 3) == 0)
         velocity = VEL_W'($signed($urandom_range(0, 2048)) - 1024);
      else
         velocity = VEL_W'($urandom);
      offer(measured, target, velocity, $urandom_range(0, 29) == 0);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return GAIN_MAX;
         2: return GAIN_W'($urandom_range(0, 255));
         3: return GAIN_W'($urandom_range(256, 4096));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_max_duty();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return GAIN_MAX;
         default: return GAIN_W'($urandom_range(1, 4000));
      endcase
   endfunction

   // drain everything before touching the registers
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= '0;
      csr_wr_data            <= '0;
      req_if.valid           <= 1'b0;
      req_if.measured_pos    <= '0;
      req_if.target_pos      <= '0;
      req_if.target_velocity <= '0;
      req_if.clear_state     <= 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register reset values
      offer(0, 0, 0, 1'b0);
      offer(100, 612, 300, 1'b0);
      finish_phase();

      program_regs(256, 64, 640, 100, 1500);
      offer(0, 2560, 0, 1'b0);
      offer(2560, 0, 0, 1'b0);
      offer(-300, -301, -1, 1'b0);
      offer(POS_MAX, POS_MIN, VEL_MAX, 1'b0);
      offer(POS_MIN, POS_MAX, VEL_MIN, 1'b0);
      offer(0, 0, VEL_MAX, 1'b0);
      offer(0, 0, VEL_MIN, 1'b1);
      finish_phase();

      // full gains, wide clamp: integral runs into both limits
      program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, 0, GAIN_MAX);
      repeat (6) offer(0, 8000, VEL_MIN, 1'b0);
      repeat (9) offer(0, -8000, 0, 1'b0);
      offer(0, 0, 0, 1'b1);
      finish_phase();

      // zero clamp freezes the integral
      program_regs(256, 256, 256, 50, 0);
      offer(0, 2560, 100, 1'b0);
      offer(0, -2560, 0, 1'b0);
      finish_phase();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_max_duty());
         if (phase == RANDOM_PHASES / 2) begin
            long_hold_request = 1'b1;
            burst_left = 40;
         end
         repeat (PHASE_ITEMS) offer_random();
         finish_phase();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// File: sim.f
design/pos_pi_pkg.sv
design/pos_pi_if.sv
design/position_pi_feedforward_pwm_top.sv
dv/tb.sv
